// ===== sv/pks_pkg.sv =====
// Shared types, constants and the control store for the pancake sorter.
// Depends on nothing; used by pancake_sorter_core.
package pks_pkg;

   // Default sizes of the element store and the value word.
   localparam int DEF_MAX_ITEMS  = 64;
   localparam int DEF_VALUE_BITS = 16;

   // Width of the step counter and of a jump target.
   localparam int UPC_BITS = 5;

   typedef logic [UPC_BITS-1:0] upc_type;

   // Datapath action driven by one control word.
   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_SIZE_SET,
      ACT_SCAN_INIT,
      ACT_SCAN_RD,
      ACT_SCAN_CMP,
      ACT_REV1_INIT,
      ACT_REV2_INIT,
      ACT_SWAP_A,
      ACT_SWAP_B,
      ACT_SWAP_C,
      ACT_SWAP_D,
      ACT_SIZE_DEC,
      ACT_OUT_INIT,
      ACT_OUT_RD,
      ACT_OUT_LD,
      ACT_CLEAR
   } act_type;

   // Jump condition; the step counter takes the target when it holds.
   typedef enum logic [3:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NOT_LAST_ACCEPT,
      COND_SIZE_LE1,
      COND_SCAN_MORE,
      COND_BEST_AT_END,
      COND_LO_GE_HI,
      COND_OUT_BUSY,
      COND_OUT_MORE
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      upc_type  target;
   } uword_type;

   // Step addresses of the program.
   localparam upc_type ST_IDLE      = 5'd0;
   localparam upc_type ST_SORT_INIT = 5'd1;
   localparam upc_type ST_SIZE_TEST = 5'd2;
   localparam upc_type ST_SCAN_INIT = 5'd3;
   localparam upc_type ST_SCAN_RD   = 5'd4;
   localparam upc_type ST_SCAN_CMP  = 5'd5;
   localparam upc_type ST_TOP_TEST  = 5'd6;
   localparam upc_type ST_R1_INIT   = 5'd7;
   localparam upc_type ST_R1_TEST   = 5'd8;
   localparam upc_type ST_R1_A      = 5'd9;
   localparam upc_type ST_R1_B      = 5'd10;
   localparam upc_type ST_R1_C      = 5'd11;
   localparam upc_type ST_R1_D      = 5'd12;
   localparam upc_type ST_R2_INIT   = 5'd13;
   localparam upc_type ST_R2_TEST   = 5'd14;
   localparam upc_type ST_R2_A      = 5'd15;
   localparam upc_type ST_R2_B      = 5'd16;
   localparam upc_type ST_R2_C      = 5'd17;
   localparam upc_type ST_R2_D      = 5'd18;
   localparam upc_type ST_SIZE_DEC  = 5'd19;
   localparam upc_type ST_OUT_INIT  = 5'd20;
   localparam upc_type ST_OUT_WAIT  = 5'd21;
   localparam upc_type ST_OUT_RD    = 5'd22;
   localparam upc_type ST_OUT_LD    = 5'd23;
   localparam upc_type ST_OUT_TEST  = 5'd24;
   localparam upc_type ST_DONE      = 5'd25;

   // The control program: one word per step.
   function automatic uword_type ucode_rom(upc_type upc);
      uword_type w;
      begin
         w = '{act: ACT_NONE, cond: COND_ALWAYS, target: ST_IDLE};
         unique case (upc)
            ST_IDLE:      w = '{ACT_LOAD,      COND_NOT_LAST_ACCEPT, ST_IDLE};
            ST_SORT_INIT: w = '{ACT_SIZE_SET,  COND_NEXT,            ST_IDLE};
            ST_SIZE_TEST: w = '{ACT_NONE,      COND_SIZE_LE1,        ST_OUT_INIT};
            ST_SCAN_INIT: w = '{ACT_SCAN_INIT, COND_NEXT,            ST_IDLE};
            ST_SCAN_RD:   w = '{ACT_SCAN_RD,   COND_NEXT,            ST_IDLE};
            ST_SCAN_CMP:  w = '{ACT_SCAN_CMP,  COND_SCAN_MORE,       ST_SCAN_RD};
            ST_TOP_TEST:  w = '{ACT_NONE,      COND_BEST_AT_END,     ST_SIZE_DEC};
            ST_R1_INIT:   w = '{ACT_REV1_INIT, COND_NEXT,            ST_IDLE};
            ST_R1_TEST:   w = '{ACT_NONE,      COND_LO_GE_HI,        ST_R2_INIT};
            ST_R1_A:      w = '{ACT_SWAP_A,    COND_NEXT,            ST_IDLE};
            ST_R1_B:      w = '{ACT_SWAP_B,    COND_NEXT,            ST_IDLE};
            ST_R1_C:      w = '{ACT_SWAP_C,    COND_NEXT,            ST_IDLE};
            ST_R1_D:      w = '{ACT_SWAP_D,    COND_ALWAYS,          ST_R1_TEST};
            ST_R2_INIT:   w = '{ACT_REV2_INIT, COND_NEXT,            ST_IDLE};
            ST_R2_TEST:   w = '{ACT_NONE,      COND_LO_GE_HI,        ST_SIZE_DEC};
            ST_R2_A:      w = '{ACT_SWAP_A,    COND_NEXT,            ST_IDLE};
            ST_R2_B:      w = '{ACT_SWAP_B,    COND_NEXT,            ST_IDLE};
            ST_R2_C:      w = '{ACT_SWAP_C,    COND_NEXT,            ST_IDLE};
            ST_R2_D:      w = '{ACT_SWAP_D,    COND_ALWAYS,          ST_R2_TEST};
            ST_SIZE_DEC:  w = '{ACT_SIZE_DEC,  COND_ALWAYS,          ST_SIZE_TEST};
            ST_OUT_INIT:  w = '{ACT_OUT_INIT,  COND_NEXT,            ST_IDLE};
            ST_OUT_WAIT:  w = '{ACT_NONE,      COND_OUT_BUSY,        ST_OUT_WAIT};
            ST_OUT_RD:    w = '{ACT_OUT_RD,    COND_NEXT,            ST_IDLE};
            ST_OUT_LD:    w = '{ACT_OUT_LD,    COND_NEXT,            ST_IDLE};
            ST_OUT_TEST:  w = '{ACT_NONE,      COND_OUT_MORE,        ST_OUT_WAIT};
            ST_DONE:      w = '{ACT_CLEAR,     COND_ALWAYS,          ST_IDLE};
            default:      w = '{ACT_NONE,      COND_ALWAYS,          ST_IDLE};
         endcase
         return w;
      end
   endfunction

endpackage

// ===== sv/pks_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pks_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pancake_sorter_core.sv =====
// Pancake sorter top level: microcoded sequencer, element store and result register.
// Depends on pks_pkg and pks_ram.
//
//   Channel   Ports                                 Direction  Meaning
//   request   req_valid/ready, value, final_item    in         one element of the set
//   response  rsp_valid/ready, sorted_value, final  out        sorted elements, last marked
//
// A non-final item is taken without leaving the load step. After the final item
// the store of N elements is sorted by passes of size s = N..2: each pass scans
// the prefix one element at a time, then, unless the largest is already at the
// end, runs two reversals, one swap at a time, through the store's single read port.
// Results then leave one at a time, each read once the response register is free.
// Reset is synchronous and clears the step counter, the fill count and the
// response valid; the store needs no clearing. A stalled response holds its item.
module pancake_sorter_core
   #(
      parameter int MAX_ITEMS  = pks_pkg::DEF_MAX_ITEMS,
      parameter int VALUE_BITS = pks_pkg::DEF_VALUE_BITS
   ) (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  req_valid,
      output logic                  req_ready,
      input  logic [VALUE_BITS-1:0] req_value,
      input  logic                  req_final_item,
      output logic                  rsp_valid,
      input  logic                  rsp_ready,
      output logic [VALUE_BITS-1:0] rsp_sorted_value,
      output logic                  rsp_final_result
   );

   import pks_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ITEMS);
   localparam logic [CW-1:0] ONE        = CW'(1);

   // Control state.
   upc_type         upc_ff, upc_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [CW-1:0]         size_ff, size_in;
   logic [CW-1:0]         k_ff, k_in;
   logic [CW-1:0]         best_ff, best_in;
   logic [VALUE_BITS-1:0] best_val_ff, best_val_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [VALUE_BITS-1:0] tmp_ff, tmp_in;
   logic [VALUE_BITS-1:0] out_val_ff, out_val_in;
   logic                  out_last_ff, out_last_in;

   // Store ports.
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   uword_type uw;
   logic      accept;
   logic      cond_true;

   assign uw        = ucode_rom(upc_ff);
   assign req_ready = (uw.act == ACT_LOAD);
   assign accept    = req_valid && req_ready;

   pks_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Jump condition of the current control word.
   always_comb begin
      unique case (uw.cond)
         COND_NEXT:            cond_true = 1'b0;
         COND_ALWAYS:          cond_true = 1'b1;
         COND_NOT_LAST_ACCEPT: cond_true = !(accept && req_final_item);
         COND_SIZE_LE1:        cond_true = (size_ff <= ONE);
         COND_SCAN_MORE:       cond_true = ((k_ff + ONE) < size_ff);
         COND_BEST_AT_END:     cond_true = (best_ff == (size_ff - ONE));
         COND_LO_GE_HI:        cond_true = !(lo_ff < hi_ff);
         COND_OUT_BUSY:        cond_true = rsp_valid_ff && !rsp_ready;
         COND_OUT_MORE:        cond_true = (k_ff != count_ff);
         default:              cond_true = 1'b0;
      endcase
   end

   // Step counter.
   always_comb begin
      upc_in = cond_true ? uw.target : upc_ff + upc_type'(1);
   end

   // Datapath actions.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      size_in      = size_ff;
      k_in         = k_ff;
      best_in      = best_ff;
      best_val_in  = best_val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      tmp_in       = tmp_ff;
      out_val_in   = out_val_ff;
      out_last_in  = out_last_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = req_value;
      rd_addr      = k_ff[AW-1:0];
      unique case (uw.act)
         ACT_NONE: begin
         end
         ACT_LOAD: begin
            // Items past a full store are dropped.
            if (accept && (count_ff < FULL_COUNT)) begin
               wr_en    = 1'b1;
               count_in = count_ff + ONE;
            end
         end
         ACT_SIZE_SET: begin
            size_in = count_ff;
         end
         ACT_SCAN_INIT: begin
            k_in    = '0;
            best_in = '0;
         end
         ACT_SCAN_RD: begin
            rd_addr = k_ff[AW-1:0];
         end
         ACT_SCAN_CMP: begin
            // Strictly greater keeps the first position of the largest value.
            if ((k_ff == '0) || ($signed(rd_data) > $signed(best_val_ff))) begin
               best_in     = k_ff;
               best_val_in = rd_data;
            end
            k_in = k_ff + ONE;
         end
         ACT_REV1_INIT: begin
            lo_in = '0;
            hi_in = best_ff;
         end
         ACT_REV2_INIT: begin
            lo_in = '0;
            hi_in = size_ff - ONE;
         end
         ACT_SWAP_A: begin
            rd_addr = lo_ff[AW-1:0];
         end
         ACT_SWAP_B: begin
            tmp_in  = rd_data;
            rd_addr = hi_ff[AW-1:0];
         end
         ACT_SWAP_C: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[AW-1:0];
            wr_data = rd_data;
         end
         ACT_SWAP_D: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff[AW-1:0];
            wr_data = tmp_ff;
            lo_in   = lo_ff + ONE;
            hi_in   = hi_ff - ONE;
         end
         ACT_SIZE_DEC: begin
            size_in = size_ff - ONE;
         end
         ACT_OUT_INIT: begin
            k_in = '0;
         end
         ACT_OUT_RD: begin
            rd_addr = k_ff[AW-1:0];
         end
         ACT_OUT_LD: begin
            out_val_in   = rd_data;
            out_last_in  = ((k_ff + ONE) == count_ff);
            rsp_valid_in = 1'b1;
            k_in         = k_ff + ONE;
         end
         ACT_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      k_ff        <= k_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      tmp_ff      <= tmp_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = out_val_ff;
   assign rsp_final_result = out_last_ff;

endmodule

// ===== tb/sv/tb_pancake_sorter_core.sv =====
// Self-checking testbench for pancake_sorter_core: directed sets, then random sets with
// random idling on both channels. Depends on pks_pkg and the pancake_sorter_core RTL.
module tb_pancake_sorter_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VB   = pks_pkg::DEF_VALUE_BITS;
   localparam int MAXN = pks_pkg::DEF_MAX_ITEMS;

   localparam int RANDOM_ITEMS   = 430;
   localparam int STALL_LIMIT    = 100000;
   localparam int HOLD_CYCLES    = 600;
   localparam int HOLD_AFTER     = 40;
   localparam int DRAIN_CYCLES   = 200;
   localparam int CALM_FIRST     = 200;
   localparam int CALM_LAST      = 300;

   typedef struct {
      logic [VB-1:0] value;
      logic          last;
   } sorted_item_type;

   // One row of the directed table; typed_n > 0 means the sorted set is written out here.
   typedef struct {
      logic [VB-1:0]         value;
      bit                    fin;
      int                    typed_n;
      logic [3:0][VB-1:0]    typed;
   } row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [VB-1:0] req_value = '0;
   logic          req_final_item = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [VB-1:0] rsp_sorted_value;
   logic          rsp_final_result;

   // Predictor state and the results still owed by the block.
   logic [VB-1:0]   element_copy [MAXN];
   int              fill_count = 0;
   logic [VB-1:0]   sorted_batch [$];
   sorted_item_type sorted_due [$];
   row_type         directed_rows [$];

   int  mismatches = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   bit  calm = 1'b0;

   pancake_sorter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_final_item   (req_final_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result)
   );

   always #4 clock = ~clock;

   // Reverse the predictor's store from position 0 up to position last.
   function automatic void flip_prefix(input int last);
      int            lo;
      int            hi;
      logic [VB-1:0] t;
      lo = 0;
      hi = last;
      while (lo < hi) begin
         t = element_copy[lo];
         element_copy[lo] = element_copy[hi];
         element_copy[hi] = t;
         lo++;
         hi--;
      end
   endfunction

   // Take one item into the predictor; on a final item leave the sorted set in sorted_batch.
   function automatic void pancake_step(input logic [VB-1:0] v, input bit fin);
      int n;
      int size;
      int top;
      int k;
      sorted_batch.delete();
      if (fill_count < MAXN) begin
         element_copy[fill_count] = v;
         fill_count++;
      end
      if (!fin) return;
      n = fill_count;
      for (size = n; size > 1; size--) begin
         top = 0;
         for (k = 1; k < size; k++) begin
            if ($signed(element_copy[k]) > $signed(element_copy[top])) top = k;
         end
         if (top != size - 1) begin
            flip_prefix(top);
            flip_prefix(size - 1);
         end
      end
      for (k = 0; k < n; k++) sorted_batch.push_back(element_copy[k]);
      fill_count = 0;
   endfunction

   // Queue the predicted results of the last item, marking the final one.
   function automatic void owe_batch();
      int k;
      for (k = 0; k < sorted_batch.size(); k++) begin
         sorted_due.push_back('{value: sorted_batch[k], last: (k == sorted_batch.size() - 1)});
      end
   endfunction

   function automatic void add_row(input logic [VB-1:0] v, input bit fin, input int n,
                                   input logic [VB-1:0] t0, input logic [VB-1:0] t1,
                                   input logic [VB-1:0] t2);
      row_type r;
      r.value   = v;
      r.fin     = fin;
      r.typed_n = n;
      r.typed   = '0;
      r.typed[0] = t0;
      r.typed[1] = t1;
      r.typed[2] = t2;
      directed_rows.push_back(r);
   endfunction

   // Value for a random set: full range, a narrow range full of ties, or mostly the extremes.
   function automatic logic [VB-1:0] pick_value(input int mode);
      logic [VB-1:0] v;
      case (mode)
         0: v = VB'($urandom);
         1: v = VB'($urandom_range(0, 6) - 3);
         default: begin
            case ($urandom_range(0, 4))
               0: v = {1'b1, {(VB-1){1'b0}}};
               1: v = {1'b0, {(VB-1){1'b1}}};
               2: v = '0;
               3: v = '1;
               default: v = VB'($urandom);
            endcase
         end
      endcase
      return v;
   endfunction

   // Offer one item, idling first at random, and return at the edge that accepts it.
   task automatic offer_item(input logic [VB-1:0] v, input bit fin);
      if (!calm && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 32);
      end
      req_valid      <= 1'b1;
      req_value      <= v;
      req_final_item <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
   endtask

   // Stimulus: directed table, random sets, then drain and verdict.
   initial begin
      int   r;
      int   k;
      int   set_no;
      int   set_size;
      int   mode;
      int   random_sent;
      logic [VB-1:0] v;
      bit   fin;

      // Lone extremes, both extremes together, an ascending set, ties.
      add_row(16'h7fff, 1'b1, 1, 16'h7fff, 16'h0000, 16'h0000);
      add_row(16'h8000, 1'b1, 1, 16'h8000, 16'h0000, 16'h0000);
      add_row(16'h7fff, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h8000, 1'b1, 2, 16'h8000, 16'h7fff, 16'h0000);
      add_row(16'hffff, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0000, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0001, 1'b1, 3, 16'hffff, 16'h0000, 16'h0001);
      add_row(16'h0005, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0005, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0005, 1'b1, 3, 16'h0005, 16'h0005, 16'h0005);
      // A descending set and one with a repeated maximum go to the predictor.
      add_row(16'h0064, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0032, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h000a, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0000, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'hfff6, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'hffce, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'hff9c, 1'b1, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0003, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0009, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'hfffe, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0009, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0000, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0009, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'hfff9, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
      add_row(16'h0001, 1'b1, 0, 16'h0000, 16'h0000, 16'h0000);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         offer_item(directed_rows[r].value, directed_rows[r].fin);
         pancake_step(directed_rows[r].value, directed_rows[r].fin);
         if (directed_rows[r].fin) begin
            if (directed_rows[r].typed_n > 0) begin
               for (k = 0; k < directed_rows[r].typed_n; k++) begin
                  sorted_due.push_back('{value: directed_rows[r].typed[k],
                                         last: (k == directed_rows[r].typed_n - 1)});
               end
            end else begin
               owe_batch();
            end
         end
      end

      // Random sets: mostly small, some large, two that overrun the store.
      set_no = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (set_no == 1 || set_no == 12) set_size = MAXN + $urandom_range(1, 8);
         else if (r < 80) set_size = $urandom_range(1, 10);
         else if (r < 95) set_size = $urandom_range(11, 40);
         else set_size = $urandom_range(41, MAXN);
         mode = $urandom_range(0, 9);
         mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
         for (k = 0; k < set_size; k++) begin
            v   = pick_value(mode);
            fin = (k == set_size - 1);
            offer_item(v, fin);
            pancake_step(v, fin);
            if (fin) owe_batch();
            random_sent++;
         end
         set_no++;
      end
      req_valid <= 1'b0;

      while (sorted_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && sorted_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Response side: random stalls, one long hold-off once the first sets are out.
   initial begin
      bit held;
      held = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held && results_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 32);
         end
      end
   end

   // Compare each accepted result with the oldest one owed.
   always @(posedge clock) begin
      sorted_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (sorted_due.size() == 0) begin
            $display("%0t unexpected result: sorted_value %h final_result %b", $realtime,
                     rsp_sorted_value, rsp_final_result);
            mismatches++;
         end else begin
            want = sorted_due.pop_front();
            if (rsp_sorted_value !== want.value) begin
               $display("%0t sorted_value expected %h actual %h", $realtime, want.value,
                        rsp_sorted_value);
               mismatches++;
            end
            if (rsp_final_result !== want.last) begin
               $display("%0t final_result expected %b actual %b", $realtime, want.last,
                        rsp_final_result);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t no item moved for %0d cycles", $realtime, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
